[rtl/alarm_clock_controller_core_macros.svh]
// ----------------------------------------------------------------------------
// Alarm clock controller assertion macros
// Shared assertion shorthands for the checker of the alarm clock core.
// ----------------------------------------------------------------------------
`ifndef ALARM_CLOCK_CONTROLLER_CORE_MACROS_SVH
`define ALARM_CLOCK_CONTROLLER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ACC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ACC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/acc_pkg.sv]
// ----------------------------------------------------------------------------
// Alarm clock controller package
// Types, codes, reset values and small helper functions of the alarm clock.
// ----------------------------------------------------------------------------
package acc_pkg;

    // Clock modes.
    localparam logic [2:0] MODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_SET_HOUR  = 3'd1;
    localparam logic [2:0] MODE_SET_MIN   = 3'd2;
    localparam logic [2:0] MODE_SET_AHOUR = 3'd3;
    localparam logic [2:0] MODE_SET_AMIN  = 3'd4;

    // Key scan codes.
    localparam logic [7:0] KEY_NONE  = 8'h00;
    localparam logic [7:0] KEY_SETUP = 8'h11;
    localparam logic [7:0] KEY_ALARM = 8'h81;
    localparam logic [7:0] KEY_PLUS  = 8'h18;
    localparam logic [7:0] KEY_MINUS = 8'h28;

    // Item kinds carried on the input user bit.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd0;
    localparam logic [2:0] REG_BLINK_HALF_POINT = 3'd1;
    localparam logic [2:0] REG_RING_DURATION    = 3'd2;
    localparam logic [2:0] REG_SETUP_TIMEOUT    = 3'd3;
    localparam logic [2:0] REG_BEEP_DURATION    = 3'd4;

    // Register reset values.
    localparam logic [15:0] RST_TICKS_PER_SECOND = 16'd1000;
    localparam logic [15:0] RST_BLINK_HALF_POINT = 16'd500;
    localparam logic [15:0] RST_RING_DURATION    = 16'd5000;
    localparam logic [15:0] RST_SETUP_TIMEOUT    = 16'd30000;
    localparam logic [15:0] RST_BEEP_DURATION    = 16'd300;

    // Counter limits.
    localparam logic [5:0] SIXTY      = 6'd60;
    localparam logic [5:0] HOURS_DAY  = 6'd24;

    // Widths of the streams.
    localparam int RESULT_W = 21;
    localparam int M_DATA_W = 24;

    // Clock state.
    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [15:0] subsecond;
        logic [4:0]  alarm_hours;
        logic [5:0]  alarm_minutes;
        logic [15:0] idle_count;
        logic [15:0] beep_left;
        logic [15:0] ring_left;
        logic        blink;
        logic        alarm_fired;
    } t_state;

    // One result word; the last member lands in the lowest bits.
    typedef struct packed {
        logic       alarm_store;
        logic       buzzer_on;
        logic       led_on;
        logic       minute_blank;
        logic       hour_blank;
        logic [3:0] minute_ones;
        logic [2:0] minute_tens;
        logic [3:0] hour_ones;
        logic [1:0] hour_tens;
        logic [2:0] mode;
    } t_result;

    // Count up with wrap to zero at the limit.
    function automatic logic [5:0] step_up(input logic [5:0] v, input logic [5:0] lim);
        logic [6:0] inc;
        inc = {1'b0, v} + 7'd1;
        return (inc >= {1'b0, lim}) ? 6'd0 : inc[5:0];
    endfunction

    // Count down with wrap to the limit less one.
    function automatic logic [5:0] step_down(input logic [5:0] v, input logic [5:0] lim);
        return (v == 6'd0) ? (lim - 6'd1) : (v - 6'd1);
    endfunction

    // Tens digit of a value below sixty four.
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)      t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

endpackage

[rtl/acc_display.sv]
// ----------------------------------------------------------------------------
// Alarm clock display decode
// Turns the clock state into display digits, blanking, LED and buzzer level.
// ----------------------------------------------------------------------------
module acc_display (
    input  acc_pkg::t_state  i_state,
    input  logic [15:0]      i_blink_half_point,
    input  logic             i_store,
    output acc_pkg::t_result o_result
);

    logic       alarm_mode;
    logic       hour_mode;
    logic       minute_mode;
    logic [5:0] shown_hour;
    logic [5:0] shown_minute;
    logic [2:0] hour_tens;
    logic [2:0] minute_tens;
    logic [5:0] hour_ones;
    logic [5:0] minute_ones;

    // Which field is being edited, and which value is on show.
    assign alarm_mode   = (i_state.mode == acc_pkg::MODE_SET_AHOUR) ||
                          (i_state.mode == acc_pkg::MODE_SET_AMIN);
    assign hour_mode    = (i_state.mode == acc_pkg::MODE_SET_HOUR) ||
                          (i_state.mode == acc_pkg::MODE_SET_AHOUR);
    assign minute_mode  = (i_state.mode == acc_pkg::MODE_SET_MIN) ||
                          (i_state.mode == acc_pkg::MODE_SET_AMIN);
    assign shown_hour   = alarm_mode ? {1'b0, i_state.alarm_hours} : {1'b0, i_state.hours};
    assign shown_minute = alarm_mode ? i_state.alarm_minutes : i_state.minutes;

    // Decimal digits by comparison and a constant multiply.
    assign hour_tens   = acc_pkg::tens_of(shown_hour);
    assign minute_tens = acc_pkg::tens_of(shown_minute);
    assign hour_ones   = shown_hour - ({3'b0, hour_tens} * 6'd10);
    assign minute_ones = shown_minute - ({3'b0, minute_tens} * 6'd10);

    // Assemble the result word.
    always_comb begin
        o_result.mode         = i_state.mode;
        o_result.hour_tens    = hour_tens[1:0];
        o_result.hour_ones    = hour_ones[3:0];
        o_result.minute_tens  = minute_tens;
        o_result.minute_ones  = minute_ones[3:0];
        o_result.hour_blank   = hour_mode && !i_state.blink;
        o_result.minute_blank = minute_mode && !i_state.blink;
        o_result.led_on       = alarm_mode && i_state.blink;
        o_result.alarm_store  = i_store;
        if (i_state.beep_left != 16'd0) begin
            o_result.buzzer_on = 1'b1;
        end else if (i_state.ring_left != 16'd0) begin
            o_result.buzzer_on = (i_state.subsecond < i_blink_half_point);
        end else begin
            o_result.buzzer_on = 1'b0;
        end
    end

endmodule

[rtl/alarm_clock_controller_core.sv]
// ----------------------------------------------------------------------------
// Alarm clock controller core
// Twenty-four-hour alarm clock driven by tick and key words, with a result
// word of display digits and flags for every input word.
//
// Channel  Direction  Content
// s_axis   in         tuser: cmd; tdata: key_code
// m_axis   out        tdata: mode, digits, blanking, LED, buzzer, store strobe
// apb      in/out     five 16-bit registers at byte addresses 0 to 16
//
// One word is taken per cycle while the output can accept it; its result
// is registered in the output register, computed by the combinational
// next-state logic that reads the clock state registers directly.
// Synchronous reset sets state and config registers; no clearing pass.
// A new word is taken while the output register is empty or being read out.
// ----------------------------------------------------------------------------
module alarm_clock_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
    input  logic        s_axis_tuser,   // [0] cmd
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] mode, [4:3] hour_tens, [8:5] hour_ones, [11:9] minute_tens,
    // [15:12] minute_ones, [16] hour_blank, [17] minute_blank, [18] led_on,
    // [19] buzzer_on, [20] alarm_store, [23:21] zero
    output logic [23:0] m_axis_tdata,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]      r_ticks_per_second;
    logic [15:0]      r_blink_half_point;
    logic [15:0]      r_ring_duration;
    logic [15:0]      r_setup_timeout;
    logic [15:0]      r_beep_duration;
    acc_pkg::t_state  r_state;
    acc_pkg::t_state  n_state;
    logic             n_store;
    acc_pkg::t_result n_result;
    acc_pkg::t_result r_result;
    logic             r_out_valid;
    logic             in_accept;
    logic             cfg_write;
    logic [2:0]       reg_index;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second <= acc_pkg::RST_TICKS_PER_SECOND;
            r_blink_half_point <= acc_pkg::RST_BLINK_HALF_POINT;
            r_ring_duration    <= acc_pkg::RST_RING_DURATION;
            r_setup_timeout    <= acc_pkg::RST_SETUP_TIMEOUT;
            r_beep_duration    <= acc_pkg::RST_BEEP_DURATION;
        end else if (cfg_write) begin
            case (reg_index)
                acc_pkg::REG_TICKS_PER_SECOND: r_ticks_per_second <= pwdata[15:0];
                acc_pkg::REG_BLINK_HALF_POINT: r_blink_half_point <= pwdata[15:0];
                acc_pkg::REG_RING_DURATION:    r_ring_duration    <= pwdata[15:0];
                acc_pkg::REG_SETUP_TIMEOUT:    r_setup_timeout    <= pwdata[15:0];
                acc_pkg::REG_BEEP_DURATION:    r_beep_duration    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_index)
            acc_pkg::REG_TICKS_PER_SECOND: prdata = {16'd0, r_ticks_per_second};
            acc_pkg::REG_BLINK_HALF_POINT: prdata = {16'd0, r_blink_half_point};
            acc_pkg::REG_RING_DURATION:    prdata = {16'd0, r_ring_duration};
            acc_pkg::REG_SETUP_TIMEOUT:    prdata = {16'd0, r_setup_timeout};
            acc_pkg::REG_BEEP_DURATION:    prdata = {16'd0, r_beep_duration};
            default:                       prdata = 32'd0;
        endcase
    end

    // Handshake: the output register parts the two sides.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Next clock state for the word on the input.
    always_comb begin
        logic [15:0] sub_inc;
        logic [15:0] idle_inc;
        sub_inc  = r_state.subsecond + 16'd1;
        idle_inc = r_state.idle_count + 16'd1;
        n_state  = r_state;
        n_store  = 1'b0;
        if (s_axis_tuser == acc_pkg::CMD_TICK) begin
            // Time of day and the alarm check at each second wrap.
            n_state.subsecond = sub_inc;
            if (sub_inc >= r_ticks_per_second) begin
                n_state.subsecond = 16'd0;
                n_state.seconds   = acc_pkg::step_up(r_state.seconds, acc_pkg::SIXTY);
                if (n_state.seconds == 6'd0) begin
                    n_state.minutes = acc_pkg::step_up(r_state.minutes, acc_pkg::SIXTY);
                    if (n_state.minutes == 6'd0) begin
                        n_state.hours = 5'(acc_pkg::step_up({1'b0, r_state.hours},
                                                            acc_pkg::HOURS_DAY));
                    end
                end
                if ((r_state.mode == acc_pkg::MODE_NORMAL) &&
                    (n_state.hours == r_state.alarm_hours) &&
                    (n_state.minutes == r_state.alarm_minutes)) begin
                    if (!r_state.alarm_fired) begin
                        n_state.ring_left   = r_ring_duration;
                        n_state.alarm_fired = 1'b1;
                    end
                end else begin
                    n_state.alarm_fired = 1'b0;
                end
            end
            if ((n_state.subsecond == r_blink_half_point) || (n_state.subsecond == 16'd0)) begin
                n_state.blink = !r_state.blink;
            end
            // Setup timeout ends a setting mode with a beep.
            if (r_state.mode != acc_pkg::MODE_NORMAL) begin
                n_state.idle_count = idle_inc;
                if (idle_inc >= r_setup_timeout) begin
                    n_state.mode       = acc_pkg::MODE_NORMAL;
                    n_state.idle_count = 16'd0;
                    n_state.beep_left  = r_beep_duration;
                end
            end
            // Beep and ring timers run down.
            if (n_state.beep_left != 16'd0) begin
                n_state.beep_left = n_state.beep_left - 16'd1;
            end
            if (n_state.ring_left != 16'd0) begin
                n_state.ring_left = n_state.ring_left - 16'd1;
            end
        end else if (s_axis_tdata != acc_pkg::KEY_NONE) begin
            // Any key beeps, clears the timeout and stops the ring.
            n_state.beep_left  = r_beep_duration;
            n_state.idle_count = 16'd0;
            n_state.ring_left  = 16'd0;
            unique case (r_state.mode)
                acc_pkg::MODE_NORMAL: begin
                    priority if (s_axis_tdata == acc_pkg::KEY_SETUP) begin
                        n_state.mode = acc_pkg::MODE_SET_HOUR;
                    end else if (s_axis_tdata == acc_pkg::KEY_ALARM) begin
                        n_state.mode = acc_pkg::MODE_SET_AHOUR;
                    end else begin
                    end
                end
                acc_pkg::MODE_SET_HOUR: begin
                    priority if (s_axis_tdata == acc_pkg::KEY_SETUP) begin
                        n_state.mode = acc_pkg::MODE_SET_MIN;
                    end else if (s_axis_tdata == acc_pkg::KEY_PLUS) begin
                        n_state.hours = 5'(acc_pkg::step_up({1'b0, r_state.hours},
                                                            acc_pkg::HOURS_DAY));
                    end else if (s_axis_tdata == acc_pkg::KEY_MINUS) begin
                        n_state.hours = 5'(acc_pkg::step_down({1'b0, r_state.hours},
                                                              acc_pkg::HOURS_DAY));
                    end else begin
                    end
                end
                acc_pkg::MODE_SET_MIN: begin
                    priority if (s_axis_tdata == acc_pkg::KEY_SETUP) begin
                        n_state.mode = acc_pkg::MODE_NORMAL;
                    end else if (s_axis_tdata == acc_pkg::KEY_PLUS) begin
                        n_state.minutes = acc_pkg::step_up(r_state.minutes, acc_pkg::SIXTY);
                    end else if (s_axis_tdata == acc_pkg::KEY_MINUS) begin
                        n_state.minutes = acc_pkg::step_down(r_state.minutes, acc_pkg::SIXTY);
                    end else begin
                    end
                end
                acc_pkg::MODE_SET_AHOUR: begin
                    priority if (s_axis_tdata == acc_pkg::KEY_ALARM) begin
                        n_state.mode = acc_pkg::MODE_SET_AMIN;
                    end else if (s_axis_tdata == acc_pkg::KEY_PLUS) begin
                        n_state.alarm_hours = 5'(acc_pkg::step_up({1'b0, r_state.alarm_hours},
                                                                  acc_pkg::HOURS_DAY));
                    end else if (s_axis_tdata == acc_pkg::KEY_MINUS) begin
                        n_state.alarm_hours = 5'(acc_pkg::step_down(
                                                     {1'b0, r_state.alarm_hours},
                                                     acc_pkg::HOURS_DAY));
                    end else begin
                    end
                end
                default: begin
                    // Alarm minute setting; the alarm key confirms and stores.
                    priority if (s_axis_tdata == acc_pkg::KEY_ALARM) begin
                        n_state.mode = acc_pkg::MODE_NORMAL;
                        n_store      = 1'b1;
                    end else if (s_axis_tdata == acc_pkg::KEY_PLUS) begin
                        n_state.alarm_minutes = acc_pkg::step_up(r_state.alarm_minutes,
                                                                 acc_pkg::SIXTY);
                    end else if (s_axis_tdata == acc_pkg::KEY_MINUS) begin
                        n_state.alarm_minutes = acc_pkg::step_down(r_state.alarm_minutes,
                                                                   acc_pkg::SIXTY);
                    end else begin
                    end
                end
            endcase
        end
    end

    // Display decode of the updated state.
    acc_display u_display (
        .i_state            (n_state),
        .i_blink_half_point (r_blink_half_point),
        .i_store            (n_store),
        .o_result           (n_result)
    );

    // Clock state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: acc_pkg::MODE_NORMAL, blink: 1'b1, default: '0};
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(acc_pkg::M_DATA_W - acc_pkg::RESULT_W)'(0), r_result};

endmodule

[rtl/acc_checker.sv]
// ----------------------------------------------------------------------------
// Alarm clock controller checker
// Port-level assertions on the alarm clock core, attached by bind.
// ----------------------------------------------------------------------------
`include "alarm_clock_controller_core_macros.svh"

module acc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled result word holds.
    `ACC_ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    // Reset empties the output register.
    `ACC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // Every accepted word yields a result in the next cycle.
    `ACC_ASSERT_CLK(a_one_result, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "no result after an accepted word")

    // Shown digits form a valid time of day.
    `ACC_ASSERT_CLK(a_digits, m_axis_tvalid |-> (m_axis_tdata[4:3] <= 2'd2) && (m_axis_tdata[8:5] <= 4'd9) && (m_axis_tdata[11:9] <= 3'd5) && (m_axis_tdata[15:12] <= 4'd9) && !((m_axis_tdata[4:3] == 2'd2) && (m_axis_tdata[8:5] > 4'd3)), "digits out of range")

    // The store strobe comes only with the return to normal mode.
    `ACC_ASSERT_CLK(a_store_mode, m_axis_tvalid && m_axis_tdata[20] |-> (m_axis_tdata[2:0] == acc_pkg::MODE_NORMAL), "store strobe outside normal mode")

endmodule

bind alarm_clock_controller_core acc_checker u_acc_checker (.*);
